>>> hdl/rcf_pkg.sv
// rcf_pkg: shared types and constants for the range checked ring fifo
// no dependencies; used by the interfaces and every module in hdl/

package rcf_pkg;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic signed [WORD_W-1:0] NULL_MARKER = WORD_W'(999999);
	localparam logic signed [WORD_W-1:0] UPPER_RESET = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] LOWER_RESET = {1'b1, {(WORD_W-1){1'b0}}};

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPPER_BOUND = CFG_IDX_W'(0),
		REG_LOWER_BOUND = CFG_IDX_W'(1)
	} reg_idx_t;

	typedef struct packed {
		logic  req_type;
		word_t push_value;
	} req_t;

	typedef struct packed {
		logic  push_accepted;
		word_t pop_value;
		logic  was_empty;
	} rsp_t;

	typedef struct packed {
		word_t upper_bound;
		word_t lower_bound;
	} bounds_t;

	function automatic ptr_t next_slot(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

>>> hdl/rcf_req_if.sv
// rcf_req_if: request channel (push or pop) with valid/ready handshake
// depends on rcf_pkg

interface rcf_req_if import rcf_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  req_type;
	word_t push_value;

	modport source (output valid, req_type, push_value, input ready);
	modport sink (input valid, req_type, push_value, output ready);
endinterface

>>> hdl/rcf_rsp_if.sv
// rcf_rsp_if: result channel with valid/ready handshake
// depends on rcf_pkg

interface rcf_rsp_if import rcf_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  push_accepted;
	word_t pop_value;
	logic  was_empty;

	modport source (output valid, push_accepted, pop_value, was_empty, input ready);
	modport sink (input valid, push_accepted, pop_value, was_empty, output ready);
endinterface

>>> hdl/rcf_cfg_if.sv
// rcf_cfg_if: configuration write channel, register index plus data
// depends on rcf_pkg

interface rcf_cfg_if import rcf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	word_t                data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/rcf_cfg_regs.sv
// rcf_cfg_regs: admission bound registers written over the config channel
// depends on rcf_pkg, rcf_cfg_if

module rcf_cfg_regs
	import rcf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	rcf_cfg_if.sink cfg,
	output bounds_t bounds
);

	word_t upper_q;
	word_t lower_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_RESET;
			lower_q <= LOWER_RESET;
		end else if (cfg.valid) begin
			// unknown indexes are dropped
			unique case (cfg.index)
				REG_UPPER_BOUND: upper_q <= cfg.data;
				REG_LOWER_BOUND: lower_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign bounds.upper_bound = upper_q;
	assign bounds.lower_bound = lower_q;

endmodule

>>> hdl/rcf_ring.sv
// rcf_ring: entry store, head/tail pointers and the per-request decision
// depends on rcf_pkg

module rcf_ring
	import rcf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  req_t    req,
	input  bounds_t bounds,
	output rsp_t    rsp
);

	word_t store_q [DEPTH];
	ptr_t  head_q;
	ptr_t  tail_q;

	logic  in_range;
	logic  full;
	logic  empty;
	logic  do_push;
	logic  do_pop;

	always_comb begin
		in_range = (req.push_value <= bounds.upper_bound) &&
			(req.push_value >= bounds.lower_bound);
		full     = (next_slot(tail_q) == head_q);
		empty    = (head_q == tail_q);
		do_push  = (req.req_type == REQ_PUSH) && in_range && !full;
		do_pop   = (req.req_type == REQ_POP) && !empty;

		rsp.push_accepted = do_push;
		rsp.was_empty     = (req.req_type == REQ_POP) && empty;
		rsp.pop_value     = do_pop ? store_q[head_q] : NULL_MARKER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (fire) begin
			if (do_push) begin
				tail_q <= next_slot(tail_q);
			end
			if (do_pop) begin
				head_q <= next_slot(head_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			store_q[tail_q] <= req.push_value;
		end
	end

endmodule

>>> hdl/range_checked_ring_fifo_core.sv
// Range checked ring fifo: a queue of up to DEPTH-1 signed 32-bit words
// (DEPTH is 16, one slot stays free). Each request transaction is a push or a
// pop; a push is stored only if the word lies within lower_bound..upper_bound
// inclusive and the queue is not full, a pop returns the head word or the null
// marker 999999 with was_empty set when nothing is queued. Every request gives
// exactly one result via the input register, then the result register. A new
// request is taken every cycle unless the result channel stalls; the bound
// compare and pointer update sit between the two registers. Bounds reset to
// the full signed range; the user writes them over the cfg channel (index 0
// upper_bound, index 1 lower_bound) only while idle, unenforced by the block.

module range_checked_ring_fifo_core
	import rcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rcf_req_if.sink    req,
	rcf_rsp_if.source  rsp,
	rcf_cfg_if.sink    cfg
);

	bounds_t bounds;
	logic    req_valid_s1;
	req_t    req_s1;
	logic    rsp_valid_q;
	rsp_t    rsp_q;
	rsp_t    rsp_d;
	logic    advance;

	// s1 moves into the result register when that register is free or draining
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;

	rcf_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.bounds (bounds)
	);

	rcf_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.bounds (bounds),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (req.ready) begin
				req_valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type   <= req.req_type;
			req_s1.push_value <= req.push_value;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.push_accepted = rsp_q.push_accepted;
	assign rsp.pop_value     = rsp_q.pop_value;
	assign rsp.was_empty     = rsp_q.was_empty;

	a_push_has_null: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.push_accepted |-> rsp_q.pop_value == NULL_MARKER
		&& !rsp_q.was_empty)
		else $error("accepted push carries a popped word");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.was_empty |-> rsp_q.pop_value == NULL_MARKER
		&& !rsp_q.push_accepted)
		else $error("empty pop result malformed");

	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("transaction lost between s1 and result register");

endmodule
